// ----- src/htfc_pkg.sv -----
// Shared types, constants and CRC function for the humidity/temperature frame checker
package htfc_pkg;

    localparam int FRAME_WORDS    = 2;
    localparam int BYTES_PER_WORD = 3;
    localparam int LAST_POS_I     = FRAME_WORDS * BYTES_PER_WORD - 1;

    typedef logic [2:0] pos_t;

    localparam pos_t POS_W0_HI  = 3'd0;
    localparam pos_t POS_W0_LO  = 3'd1;
    localparam pos_t POS_W0_CRC = 3'd2;
    localparam pos_t POS_W1_HI  = 3'd3;
    localparam pos_t POS_W1_LO  = 3'd4;
    localparam pos_t POS_W1_CRC = 3'd5;
    localparam pos_t LAST_POS   = pos_t'(LAST_POS_I);

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_FIRST_BAD,
        STATUS_SECOND_BAD
    } status_t;

    typedef logic [0:0] cfg_idx_t;

    localparam cfg_idx_t REG_CRC_POLY = 1'b0;
    localparam cfg_idx_t REG_CRC_INIT = 1'b1;

    localparam logic [7:0] CRC_POLY_RESET = 8'h31;
    localparam logic [7:0] CRC_INIT_RESET = 8'hFF;

    localparam int          CONV_SHIFT = 13;
    localparam logic [30:0] T_SCALE    = 31'd21875;
    localparam logic [30:0] H_SCALE    = 31'd15625;
    localparam logic [17:0] T_OFFSET   = 18'd45000;
    localparam logic [17:0] H_OFFSET   = 18'd6000;

    typedef struct packed {
        logic [15:0] first_word;
        logic [15:0] second_word;
        status_t     crc_status;
    } frame_t;

    function automatic logic [7:0] crc_update(
        input logic [7:0] crc,
        input logic [7:0] data,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- src/htfc_byte_if.sv -----
// Byte input channel
interface htfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ----- src/htfc_result_if.sv -----
// Result output channel
interface htfc_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        first_word;
    logic [15:0]        second_word;
    logic [1:0]         crc_status;
    logic signed [17:0] temperature_milli;
    logic signed [17:0] humidity_milli;

    modport source (output valid, output first_word, output second_word, output crc_status,
                    output temperature_milli, output humidity_milli, input ready);
    modport sink   (input valid, input first_word, input second_word, input crc_status,
                    input temperature_milli, input humidity_milli, output ready);
endinterface

// ----- src/htfc_cfg_if.sv -----
// Configuration write channel
interface htfc_cfg_if;
    logic                valid;
    logic                ready;
    htfc_pkg::cfg_idx_t  index;
    logic [7:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/htfc_deframer.sv -----
// Byte deframer: position tracking, per-word CRC-8 check and word assembly
module htfc_deframer (
    input  logic                clk,
    input  logic                rst_n,
    htfc_byte_if.sink           rx,
    input  logic [7:0]          crc_poly,
    input  logic [7:0]          crc_init,
    output logic                frame_valid,
    input  logic                frame_ready,
    output htfc_pkg::frame_t    frame
);

    htfc_pkg::pos_t    pos_reg, pos_next, pos_cur;
    htfc_pkg::status_t status_reg, status_next, status_base;
    logic [7:0]        crc_reg, crc_next;
    logic [7:0]        hi_reg, hi_next;
    logic [15:0]       w0_reg, w0_next;
    logic [15:0]       w1_reg, w1_next;
    logic              frame_valid_reg, frame_valid_next;
    htfc_pkg::frame_t  frame_reg, frame_next;
    logic              accept;

    assign rx.ready    = !frame_valid_reg || frame_ready;
    assign accept      = rx.valid && rx.ready;
    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    always_comb
    begin
        pos_cur = (rx.frame_start || pos_reg > htfc_pkg::LAST_POS) ?
                  htfc_pkg::POS_W0_HI : pos_reg;
        status_base = (pos_cur == htfc_pkg::POS_W0_HI) ? htfc_pkg::STATUS_OK : status_reg;

        pos_next         = pos_reg;
        status_next      = status_reg;
        crc_next         = crc_reg;
        hi_next          = hi_reg;
        w0_next          = w0_reg;
        w1_next          = w1_reg;
        frame_next       = frame_reg;
        frame_valid_next = frame_valid_reg && !frame_ready;

        if (accept)
        begin
            status_next = status_base;
            case (pos_cur)
                htfc_pkg::POS_W0_HI,
                htfc_pkg::POS_W1_HI:
                begin
                    crc_next = htfc_pkg::crc_update(crc_init, rx.rx_byte, crc_poly);
                    hi_next  = rx.rx_byte;
                end
                htfc_pkg::POS_W0_LO:
                begin
                    crc_next = htfc_pkg::crc_update(crc_reg, rx.rx_byte, crc_poly);
                    w0_next  = {hi_reg, rx.rx_byte};
                end
                htfc_pkg::POS_W1_LO:
                begin
                    crc_next = htfc_pkg::crc_update(crc_reg, rx.rx_byte, crc_poly);
                    w1_next  = {hi_reg, rx.rx_byte};
                end
                htfc_pkg::POS_W0_CRC:
                begin
                    if (crc_reg != rx.rx_byte && status_base == htfc_pkg::STATUS_OK)
                    begin
                        status_next = htfc_pkg::STATUS_FIRST_BAD;
                    end
                    crc_next = crc_init;
                end
                htfc_pkg::POS_W1_CRC:
                begin
                    if (crc_reg != rx.rx_byte && status_base == htfc_pkg::STATUS_OK)
                    begin
                        status_next = htfc_pkg::STATUS_SECOND_BAD;
                    end
                    crc_next = crc_init;
                end
                default:
                begin
                    crc_next = crc_reg;
                end
            endcase

            if (pos_cur == htfc_pkg::LAST_POS)
            begin
                pos_next               = htfc_pkg::POS_W0_HI;
                frame_valid_next       = 1'b1;
                frame_next.first_word  = w0_reg;
                frame_next.second_word = w1_reg;
                frame_next.crc_status  = status_next;
            end
            else
            begin
                pos_next = pos_cur + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= htfc_pkg::POS_W0_HI;
            status_reg      <= htfc_pkg::STATUS_OK;
            crc_reg         <= htfc_pkg::CRC_INIT_RESET;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            status_reg      <= status_next;
            crc_reg         <= crc_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        frame_reg <= frame_next;
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= htfc_pkg::LAST_POS)
        else $error("byte position out of range");

    a_last_byte_gives_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_cur == htfc_pkg::LAST_POS) |=> (frame_valid_reg && pos_reg == htfc_pkg::POS_W0_HI))
        else $error("last byte did not produce a frame");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx.frame_start) |=> (pos_reg == htfc_pkg::POS_W0_LO))
        else $error("start flag did not resynchronise");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid_reg && !frame_ready) |-> !rx.ready)
        else $error("byte taken while frame stalled");

endmodule

// ----- src/htfc_convert.sv -----
// Fixed-point conversion of the raw words and result register
module htfc_convert (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_valid,
    output logic                frame_ready,
    input  htfc_pkg::frame_t    frame,
    htfc_result_if.source       result
);

    logic              res_valid_reg, res_valid_next;
    logic [30:0]       t_prod, h_prod;
    logic [17:0]       t_milli, h_milli;
    htfc_pkg::frame_t  frame_reg;
    logic [17:0]       t_reg, h_reg;
    logic              take;

    assign frame_ready = !res_valid_reg || result.ready;
    assign take        = frame_valid && frame_ready;

    always_comb
    begin
        t_prod  = htfc_pkg::T_SCALE * {15'd0, frame.first_word};
        h_prod  = htfc_pkg::H_SCALE * {15'd0, frame.second_word};
        t_milli = t_prod[htfc_pkg::CONV_SHIFT +: 18] - htfc_pkg::T_OFFSET;
        h_milli = h_prod[htfc_pkg::CONV_SHIFT +: 18] - htfc_pkg::H_OFFSET;
        res_valid_next = take || (res_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            frame_reg <= frame;
            t_reg     <= t_milli;
            h_reg     <= h_milli;
        end
    end

    assign result.valid             = res_valid_reg;
    assign result.first_word        = frame_reg.first_word;
    assign result.second_word       = frame_reg.second_word;
    assign result.crc_status        = frame_reg.crc_status;
    assign result.temperature_milli = $signed(t_reg);
    assign result.humidity_milli    = $signed(h_reg);

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> res_valid_reg)
        else $error("frame taken but no result shown");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready) |=> ($stable(t_reg) && $stable(h_reg)))
        else $error("converted values changed under stall");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready) |-> !frame_ready)
        else $error("frame accepted into full result register");

endmodule

// ----- src/humidity_temp_frame_checker_unit.sv -----
// Top level: CRC configuration registers, deframer and conversion stage
// Takes one byte a cycle; byte ready drops only while both stages hold unread results.
// A frame's result, after its sixth byte is taken, is held first in the deframer's frame register,
// then in the conversion result register, which drives the result channel.
// Throughput: one byte per cycle while byte ready is high, so one result per six bytes.
// Reset (rst_n, asynchronous, active low) clears position and status, sets CRC to 0x31/0xFF.
module humidity_temp_frame_checker_unit (
    input  logic           clk,
    input  logic           rst_n,
    htfc_byte_if.sink      rx,
    htfc_result_if.source  result,
    htfc_cfg_if.sink       cfg
);

    logic [7:0]        crc_poly_reg, crc_poly_next;
    logic [7:0]        crc_init_reg, crc_init_next;
    logic              frame_valid;
    logic              frame_ready;
    htfc_pkg::frame_t  frame;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        crc_poly_next = crc_poly_reg;
        crc_init_next = crc_init_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                htfc_pkg::REG_CRC_POLY: crc_poly_next = cfg.data;
                htfc_pkg::REG_CRC_INIT: crc_init_next = cfg.data;
                default:                crc_poly_next = crc_poly_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg <= htfc_pkg::CRC_POLY_RESET;
            crc_init_reg <= htfc_pkg::CRC_INIT_RESET;
        end
        else
        begin
            crc_poly_reg <= crc_poly_next;
            crc_init_reg <= crc_init_next;
        end
    end

    htfc_deframer u_deframer (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .crc_poly    (crc_poly_reg),
        .crc_init    (crc_init_reg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    htfc_convert u_convert (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .result      (result)
    );

endmodule
